>>> hw/rtl/stuffed_frame_receiver_crc8_defines.svh
// ----------------------------------------------------------------------------
// Stuffed frame receiver assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_CRC8_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_CRC8_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while reset is low
`define SFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define SFR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFR_ASSERT(label, clk, rst, prop, msg)
`define SFR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Item types, register and event codes shared by the receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // wide enough for a payload count of up to 127
   localparam int SFR_FILL_W = 7;

   // register indexes
   localparam logic [1:0] CSR_FRAME_MARK = 2'd0;
   localparam logic [1:0] CSR_ESC_CODE   = 2'd1;
   localparam logic [1:0] CSR_ESC_XOR    = 2'd2;
   localparam logic [1:0] CSR_CRC_POLY   = 2'd3;

   // request types
   localparam logic REQ_LINE_BYTE = 1'b0;
   localparam logic REQ_POP       = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   // byte events
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_QUEUED   = 3'd1;
   localparam logic [2:0] EV_CRC_BAD  = 3'd2;
   localparam logic [2:0] EV_LEN_BAD  = 3'd3;
   localparam logic [2:0] EV_DROPPED  = 3'd4;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } sfr_req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [2:0] byte_event;
      logic [7:0] cmd_code;
      logic [6:0] payload_length;
      logic [7:0] payload_byte;
      logic       last;
   } sfr_rsp_type;

   typedef struct packed {
      logic [7:0] frame_mark;
      logic [7:0] esc_code;
      logic [7:0] esc_xor;
      logic [7:0] crc_poly;
   } sfr_cfg_type;

   // parser to queue: payload write, frame commit and status
   typedef struct packed {
      logic                  mem_we;
      logic [SFR_FILL_W-1:0] mem_idx;
      logic [7:0]            mem_data;
      logic                  push;
      logic [7:0]            cmd;
      logic [SFR_FILL_W-1:0] fill;
      logic [2:0]            evt;
   } sfr_parse_type;

endpackage

>>> hw/rtl/sfr_parser.sv
// ----------------------------------------------------------------------------
// Stuffed frame parser
// Unstuffs line bytes, tracks the frame fields and the running CRC-8, and
// hands payload writes and frame commits to the command queue.
// ----------------------------------------------------------------------------
module sfr_parser #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::sfr_cfg_type  cfg,
   input  logic                  take,
   input  logic [7:0]            rx_byte,
   output sfr_pkg::sfr_parse_type parse
);

   localparam int FW = $clog2(MAX_PAYLOAD + 1);

   localparam logic [2:0] PH_WAIT    = 3'd0;
   localparam logic [2:0] PH_CMD     = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CRC     = 3'd4;

   logic [2:0]    phase_ff, phase_in;
   logic          esc_ff, esc_in;
   logic [7:0]    crc_ff, crc_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    len_ff, len_in;
   logic          low_ff, low_in;
   logic [FW-1:0] fill_ff, fill_in;

   logic [7:0]    d;
   logic          use_byte;
   logic [7:0]    crc_next;
   logic [15:0]   full_len;

   // MSB-first CRC-8, init handled by the caller
   function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] b,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = acc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      crc_in   = crc_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      low_in   = low_ff;
      fill_in  = fill_ff;
      parse    = '0;
      parse.evt  = sfr_pkg::EV_NONE;
      parse.cmd  = cmd_ff;
      parse.fill = sfr_pkg::SFR_FILL_W'(fill_ff);
      d        = rx_byte;
      use_byte = 1'b0;
      if (take) begin
         if (rx_byte == cfg.frame_mark) begin
            phase_in = PH_CMD;
            fill_in  = '0;
            len_in   = '0;
            low_in   = 1'b0;
            crc_in   = '0;
            esc_in   = 1'b0;
         end else begin
            use_byte = 1'b1;
            if (phase_ff != PH_WAIT) begin
               if (esc_ff) begin
                  d      = rx_byte ^ cfg.esc_xor;
                  esc_in = 1'b0;
               end else if (rx_byte == cfg.esc_code) begin
                  esc_in   = 1'b1;
                  use_byte = 1'b0;
               end
            end
         end
      end
      crc_next = crc8_feed(crc_ff, d, cfg.crc_poly);
      full_len = {d, len_ff};
      if (use_byte) begin
         unique case (phase_ff)
            PH_CMD: begin
               cmd_in   = d;
               crc_in   = crc_next;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               crc_in = crc_next;
               if (!low_ff) begin
                  len_in = d;
                  low_in = 1'b1;
               end else begin
                  low_in = 1'b0;
                  len_in = full_len[7:0];
                  if (full_len != '0 && full_len <= 16'(MAX_PAYLOAD)) begin
                     phase_in = PH_PAYLOAD;
                  end else if (full_len == '0) begin
                     phase_in = PH_CRC;
                  end else begin
                     phase_in  = PH_WAIT;
                     fill_in   = '0;
                     len_in    = '0;
                     crc_in    = '0;
                     esc_in    = 1'b0;
                     parse.evt = sfr_pkg::EV_LEN_BAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               crc_in  = crc_next;
               fill_in = fill_ff;
               if (8'(fill_ff) < len_ff && 8'(fill_ff) < 8'(MAX_PAYLOAD)) begin
                  parse.mem_we   = 1'b1;
                  parse.mem_idx  = sfr_pkg::SFR_FILL_W'(fill_ff);
                  parse.mem_data = d;
                  fill_in        = fill_ff + 1'b1;
               end
               if (8'(fill_in) >= len_ff) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               phase_in = PH_WAIT;
               crc_in   = '0;
               if (crc_ff == d) begin
                  parse.push = 1'b1;
               end else begin
                  parse.evt = sfr_pkg::EV_CRC_BAD;
               end
            end
            default: begin
               // idle or unused phase code: back to a clean wait
               phase_in = PH_WAIT;
               fill_in  = '0;
               len_in   = '0;
               low_in   = 1'b0;
               crc_in   = '0;
               esc_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         esc_ff   <= 1'b0;
         crc_ff   <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         low_ff   <= 1'b0;
         fill_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         crc_ff   <= crc_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         low_ff   <= low_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

>>> hw/rtl/stuffed_frame_receiver_crc8.sv
// A line byte item gives one status item through the output register; the
// next item can be taken in the following cycle unless the result is
// stalled. A pop item on an empty queue also gives a single item. A pop of
// a command with n payload bytes first reads the payload memory, then gives
// one result item per cycle from its registered read port while the output
// is not stalled (a single item for n = 0), and no other item is taken until
// the last one has been loaded. Payload bytes are written straight into a
// spare queue slot while a frame arrives, so committing a frame costs no copy.
// ----------------------------------------------------------------------------
// Stuffed frame receiver with CRC-8 and command queue
// Top level: configuration registers, payload memory, queue pointers and the
// pop sequencer feeding the result register.
// ----------------------------------------------------------------------------
`include "stuffed_frame_receiver_crc8_defines.svh"

module stuffed_frame_receiver_crc8 #(
   parameter int MAX_PAYLOAD = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sfr_pkg::sfr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sfr_pkg::sfr_rsp_type rsp_data,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int SLOTS = QUEUE_DEPTH + 1;
   localparam int PW    = $clog2(SLOTS);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int FW    = $clog2(MAX_PAYLOAD + 1);
   localparam int IW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int DEPTH = SLOTS * (2 ** IW);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   sfr_pkg::sfr_cfg_type   cfg_ff;
   sfr_pkg::sfr_parse_type parse;

   logic                 state_ff, state_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [FW-1:0]        k_ff, k_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sfr_pkg::sfr_rsp_type rsp_data_ff, rsp_data_in;

   logic [7:0]           pay_mem [DEPTH];
   logic [7:0]           rd_data_ff;
   logic [7:0]           cmd_slot_ff [SLOTS];
   logic [FW-1:0]        len_slot_ff [SLOTS];

   logic                 out_free;
   logic                 accept;
   logic                 take;
   logic                 q_full;
   logic                 push_ok;
   logic                 pop_last;
   logic                 rd_en;
   logic [PW+IW-1:0]     rd_addr;
   logic [PW+IW-1:0]     wr_addr;
   logic [FW-1:0]        head_len;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH)) ? '0 : p + 1'b1;
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_mark <= 8'h7E;
         cfg_ff.esc_code   <= 8'h7D;
         cfg_ff.esc_xor    <= 8'h20;
         cfg_ff.crc_poly   <= 8'h07;
      end else if (csr_write_en) begin
         unique case (csr_index)
            sfr_pkg::CSR_FRAME_MARK: cfg_ff.frame_mark <= csr_wdata;
            sfr_pkg::CSR_ESC_CODE:   cfg_ff.esc_code   <= csr_wdata;
            sfr_pkg::CSR_ESC_XOR:    cfg_ff.esc_xor    <= csr_wdata;
            sfr_pkg::CSR_CRC_POLY:   cfg_ff.crc_poly   <= csr_wdata;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign take      = accept && (req_data.req_type == sfr_pkg::REQ_LINE_BYTE);

   sfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .take    (take),
      .rx_byte (req_data.rx_byte),
      .parse   (parse)
   );

   assign q_full   = (count_ff == CW'(QUEUE_DEPTH));
   assign push_ok  = parse.push && !q_full;
   assign head_len = len_slot_ff[head_ff];
   assign pop_last = ((FW + 1)'(k_ff) + 1'b1) >= (FW + 1)'(head_len);
   // the tail slot is always free, so a frame in flight never touches queued data
   assign wr_addr  = {tail_ff, parse.mem_idx[IW-1:0]};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      rd_en        = 1'b0;
      rd_addr      = {head_ff, IW'(0)};
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in                 = '0;
               rsp_data_in.result_kind     = sfr_pkg::KIND_STATUS;
               rsp_data_in.last            = 1'b1;
               if (parse.push) begin
                  rsp_data_in.byte_event = q_full ? sfr_pkg::EV_DROPPED : sfr_pkg::EV_QUEUED;
               end else begin
                  rsp_data_in.byte_event = parse.evt;
               end
               if (push_ok) begin
                  tail_in  = ptr_next(tail_ff);
                  count_in = count_ff + 1'b1;
               end
            end else if (accept) begin
               if (count_ff == '0) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in             = '0;
                  rsp_data_in.result_kind = sfr_pkg::KIND_EMPTY;
                  rsp_data_in.last        = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  k_in     = '0;
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.result_kind     = sfr_pkg::KIND_DATA;
               rsp_data_in.byte_event      = sfr_pkg::EV_NONE;
               rsp_data_in.cmd_code        = cmd_slot_ff[head_ff];
               rsp_data_in.payload_length  = 7'(head_len);
               rsp_data_in.payload_byte    = (head_len == '0) ? 8'h00 : rd_data_ff;
               rsp_data_in.last            = pop_last;
               if (pop_last) begin
                  state_in = ST_IDLE;
                  head_in  = ptr_next(head_ff);
                  count_in = count_ff - 1'b1;
               end else begin
                  k_in    = k_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = {head_ff, k_in[IW-1:0]};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // payload memory: one write port from the parser, one registered read port
   always_ff @(posedge clock) begin
      if (take && parse.mem_we) begin
         pay_mem[wr_addr] <= parse.mem_data;
      end
      if (rd_en) begin
         rd_data_ff <= pay_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (take && push_ok) begin
         cmd_slot_ff[tail_ff] <= parse.cmd;
         len_slot_ff[tail_ff] <= parse.fill[FW-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SFR_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(QUEUE_DEPTH), "queue count overflow")
   `SFR_ASSERT(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (head_ff == tail_ff), "empty queue with head and tail apart")
   `SFR_ASSERT(a_pop_nonempty, clock, reset, (state_ff == ST_POP) |-> (count_ff != '0), "pop streaming from an empty queue")
   `SFR_ASSERT(a_pop_retire, clock, reset, (state_ff == ST_POP && out_free && pop_last) |=> (count_ff + 1'b1 == $past(count_ff)), "pop did not retire its entry")
   `SFR_ASSERT(a_status_last, clock, reset, (rsp_valid && rsp_data.result_kind != sfr_pkg::KIND_DATA) |-> rsp_data.last, "single result item without last")

endmodule

>>> tb/sfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver result checker
// Follows register writes and accepted request items, predicts the result
// items of the frame parser and command queue, and compares every accepted
// result item field by field in order.
// ----------------------------------------------------------------------------
module sfr_frame_checker #(
   parameter int MAX_PAYLOAD = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  sfr_pkg::sfr_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sfr_pkg::sfr_rsp_type rsp_data,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   output int                   fail_count,
   output int                   pending_count
);

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_CMD,
      PH_LEN,
      PH_PAYLOAD,
      PH_CRC
   } parse_phase_type;

   sfr_pkg::sfr_cfg_type cfg;
   parse_phase_type      phase;
   logic                 esc_pending;
   logic [7:0]           crc_acc;
   logic [7:0]           frame_cmd;
   logic [15:0]          frame_len;
   logic                 len_low_seen;
   int unsigned          frame_fill;
   logic [7:0]           frame_buf [MAX_PAYLOAD];
   logic [7:0]           slot_cmd [QUEUE_DEPTH];
   logic [6:0]           slot_len [QUEUE_DEPTH];
   logic [7:0]           slot_payload [QUEUE_DEPTH][MAX_PAYLOAD];
   int unsigned          head;
   int unsigned          tail;
   int unsigned          slots_used;
   sfr_pkg::sfr_rsp_type predicted_rsps [$];
   int                   fails = 0;

   function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b, logic [7:0] poly);
      logic [7:0] c;
      c = acc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

   task automatic restart_frame();
      phase = PH_WAIT;
      frame_fill = 0;
      frame_len = '0;
      len_low_seen = 1'b0;
      crc_acc = '0;
      esc_pending = 1'b0;
   endtask

   task automatic reset_model();
      cfg = '{8'h7E, 8'h7D, 8'h20, 8'h07};
      restart_frame();
      frame_cmd = '0;
      head = 0;
      tail = 0;
      slots_used = 0;
      for (int i = 0; i < MAX_PAYLOAD; i++) frame_buf[i] = '0;
      for (int s = 0; s < QUEUE_DEPTH; s++) begin
         slot_cmd[s] = '0;
         slot_len[s] = '0;
         for (int i = 0; i < MAX_PAYLOAD; i++) slot_payload[s][i] = '0;
      end
      predicted_rsps.delete();
   endtask

   task automatic commit_frame(output logic [2:0] ev);
      if (slots_used >= QUEUE_DEPTH) begin
         ev = sfr_pkg::EV_DROPPED;
         return;
      end
      slot_cmd[tail] = frame_cmd;
      slot_len[tail] = 7'(frame_fill);
      for (int i = 0; i < frame_fill; i++) slot_payload[tail][i] = frame_buf[i];
      tail = (tail + 1) % QUEUE_DEPTH;
      slots_used++;
      ev = sfr_pkg::EV_QUEUED;
   endtask

   task automatic parse_line_byte(input logic [7:0] raw, output logic [2:0] ev);
      logic [7:0] b;
      b = raw;
      ev = sfr_pkg::EV_NONE;
      // start byte wins over everything, a pending escape included
      if (b == cfg.frame_mark) begin
         restart_frame();
         phase = PH_CMD;
         return;
      end
      if (phase != PH_WAIT) begin
         if (esc_pending) begin
            b = b ^ cfg.esc_xor;
            esc_pending = 1'b0;
         end else if (b == cfg.esc_code) begin
            esc_pending = 1'b1;
            return;
         end
      end
      case (phase)
         PH_CMD: begin
            frame_cmd = b;
            crc_acc = crc8_next(crc_acc, b, cfg.crc_poly);
            phase = PH_LEN;
         end
         PH_LEN: begin
            crc_acc = crc8_next(crc_acc, b, cfg.crc_poly);
            if (!len_low_seen) begin
               frame_len = {8'h00, b};
               len_low_seen = 1'b1;
            end else begin
               frame_len[15:8] = b;
               len_low_seen = 1'b0;
               if (frame_len == 0) begin
                  phase = PH_CRC;
               end else if (frame_len <= MAX_PAYLOAD) begin
                  phase = PH_PAYLOAD;
               end else begin
                  restart_frame();
                  ev = sfr_pkg::EV_LEN_BAD;
               end
            end
         end
         PH_PAYLOAD: begin
            crc_acc = crc8_next(crc_acc, b, cfg.crc_poly);
            if (frame_fill < frame_len && frame_fill < MAX_PAYLOAD) begin
               frame_buf[frame_fill] = b;
               frame_fill++;
            end
            if (frame_fill >= frame_len) phase = PH_CRC;
         end
         PH_CRC: begin
            phase = PH_WAIT;
            if (crc_acc == b) commit_frame(ev);
            else ev = sfr_pkg::EV_CRC_BAD;
            crc_acc = '0;
         end
         default: restart_frame();
      endcase
   endtask

   task automatic predict_item(input sfr_pkg::sfr_req_type req);
      sfr_pkg::sfr_rsp_type r;
      logic [2:0]           ev;
      int unsigned          n;
      r = '0;
      r.last = 1'b1;
      if (req.req_type == sfr_pkg::REQ_LINE_BYTE) begin
         parse_line_byte(req.rx_byte, ev);
         r.result_kind = sfr_pkg::KIND_STATUS;
         r.byte_event = ev;
         predicted_rsps.push_back(r);
      end else if (slots_used == 0) begin
         r.result_kind = sfr_pkg::KIND_EMPTY;
         predicted_rsps.push_back(r);
      end else begin
         n = slot_len[head];
         if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
         // an empty command still yields one item with a zero byte
         for (int unsigned k = 0; k == 0 || k < n; k++) begin
            r.result_kind = sfr_pkg::KIND_DATA;
            r.cmd_code = slot_cmd[head];
            r.payload_length = 7'(n);
            r.payload_byte = (k < n) ? slot_payload[head][k] : 8'h00;
            r.last = (k + 1 >= n);
            predicted_rsps.push_back(r);
         end
         head = (head + 1) % QUEUE_DEPTH;
         slots_used--;
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endtask

   task automatic compare_result(input sfr_pkg::sfr_rsp_type got);
      sfr_pkg::sfr_rsp_type want;
      if (predicted_rsps.size() == 0) begin
         $error("unexpected result item: kind %0d event %0d", got.result_kind, got.byte_event);
         fails++;
         return;
      end
      want = predicted_rsps.pop_front();
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("byte_event", want.byte_event, got.byte_event);
      check_field("cmd_code", want.cmd_code, got.cmd_code);
      check_field("payload_length", want.payload_length, got.payload_length);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("last", want.last, got.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result(rsp_data);
         if (csr_write_en) begin
            case (csr_index)
               sfr_pkg::CSR_FRAME_MARK: cfg.frame_mark = csr_wdata;
               sfr_pkg::CSR_ESC_CODE:   cfg.esc_code = csr_wdata;
               sfr_pkg::CSR_ESC_XOR:    cfg.esc_xor = csr_wdata;
               sfr_pkg::CSR_CRC_POLY:   cfg.crc_poly = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_item(req_data);
      end
      fail_count <= fails;
      pending_count <= predicted_rsps.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed frame receiver testbench
// Sends stuffed frames, broken frames, line noise and pop requests under
// several register settings with random gaps and result stalls; the checker
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_PAYLOAD     = 32;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 30;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sfr_pkg::sfr_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sfr_pkg::sfr_rsp_type rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [1:0]           csr_index = sfr_pkg::CSR_FRAME_MARK;
   logic [7:0]           csr_wdata = 8'h00;
   int                   fail_count;
   int                   pending_count;

   // register settings in force, used to stuff outgoing frames
   sfr_pkg::sfr_cfg_type line_cfg = '{8'h7E, 8'h7D, 8'h20, 8'h07};
   logic                 quiet = 1'b0;
   int                   items_sent = 0;
   int                   stall_left = 0;
   int                   cycle_count = 0;

   stuffed_frame_receiver_crc8 #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   sfr_frame_checker #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int req_gap();
      if (quiet || $urandom_range(0, 99) < 55) return 0;
      return pick_gap();
   endfunction

   function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b, logic [7:0] poly);
      logic [7:0] c;
      c = acc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

   // a byte is sendable if it needs no escape or its escaped form is not a start
   function automatic logic encodable(logic [7:0] b);
      if (b != line_cfg.frame_mark && b != line_cfg.esc_code) return 1'b1;
      return (b ^ line_cfg.esc_xor) != line_cfg.frame_mark;
   endfunction

   function automatic logic [7:0] pick_content();
      logic [7:0] b;
      b = 8'($urandom);
      while (!encodable(b)) b++;
      return b;
   endfunction

   // result stalls: random stretches, none while quiet
   always @(posedge clock) begin
      if (quiet || stall_left == 0) begin
         rsp_stall <= 1'b0;
         if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end else begin
         rsp_stall <= 1'b1;
         stall_left--;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // valid stays high between back-to-back items
   task automatic send_req(input sfr_pkg::sfr_req_type item);
      int gap;
      gap = req_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_line(input logic [7:0] b);
      sfr_pkg::sfr_req_type item;
      item.req_type = sfr_pkg::REQ_LINE_BYTE;
      item.rx_byte = b;
      send_req(item);
   endtask

   task automatic send_pop();
      sfr_pkg::sfr_req_type item;
      item.req_type = sfr_pkg::REQ_POP;
      item.rx_byte = 8'($urandom);
      send_req(item);
   endtask

   task automatic send_encoded(input logic [7:0] b);
      logic [7:0] esc_form;
      esc_form = b ^ line_cfg.esc_xor;
      if ((b == line_cfg.frame_mark || b == line_cfg.esc_code || $urandom_range(0, 9) == 0)
          && esc_form != line_cfg.frame_mark) begin
         send_line(line_cfg.esc_code);
         send_line(esc_form);
      end else begin
         send_line(b);
      end
   endtask

   // cut >= 0 stops the frame after that many unstuffed bytes
   task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                             input logic bad_crc, input int cut);
      logic [7:0] acc;
      logic [7:0] b;
      logic [7:0] hdr [3];
      int         sent;
      acc = 8'h00;
      sent = 0;
      hdr = '{cmd, len[7:0], len[15:8]};
      send_line(line_cfg.frame_mark);
      for (int i = 0; i < 3; i++) begin
         if (sent == cut) return;
         acc = crc8_next(acc, hdr[i], line_cfg.crc_poly);
         send_encoded(hdr[i]);
         sent++;
      end
      if (len > MAX_PAYLOAD) return;
      for (int i = 0; i < len; i++) begin
         if (sent == cut) return;
         b = pick_content();
         acc = crc8_next(acc, b, line_cfg.crc_poly);
         send_encoded(b);
         sent++;
      end
      if (sent == cut) return;
      if (bad_crc) acc = acc ^ 8'($urandom_range(1, 255));
      send_encoded(acc);
   endtask

   task automatic write_regs(input sfr_pkg::sfr_cfg_type c);
      csr_write_en <= 1'b1;
      csr_index <= sfr_pkg::CSR_FRAME_MARK;
      csr_wdata <= c.frame_mark;
      @(posedge clock);
      csr_index <= sfr_pkg::CSR_ESC_CODE;
      csr_wdata <= c.esc_code;
      @(posedge clock);
      csr_index <= sfr_pkg::CSR_ESC_XOR;
      csr_wdata <= c.esc_xor;
      @(posedge clock);
      csr_index <= sfr_pkg::CSR_CRC_POLY;
      csr_wdata <= c.crc_poly;
      @(posedge clock);
      csr_write_en <= 1'b0;
      line_cfg = c;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic directed_items();
      send_pop();                      // empty queue
      send_line(8'h00);                // ignored while waiting for start
      send_line(8'hFF);
      send_line(line_cfg.frame_mark);  // start, then an escape left pending for the next start
      send_line(line_cfg.esc_code);
      send_frame(8'h7E, 16'h0000, 1'b0, -1);
      send_frame(8'hFF, 16'hFFFF, 1'b0, -1);
      send_frame(8'h00, 16'h0002, 1'b1, -1);
      send_pop();
   endtask

   task automatic random_items(input int target, input int pop_pct);
      int         first;
      int         r;
      logic [15:0] len;
      first = items_sent;
      while (items_sent - first < target) begin
         r = $urandom_range(0, 99);
         if (r < 15) len = 16'd0;
         else if (r < 80) len = 16'($urandom_range(1, 4));
         else if (r < 95) len = 16'($urandom_range(5, 16));
         else len = 16'(MAX_PAYLOAD);
         if ($urandom_range(0, 99) < pop_pct) begin
            send_pop();
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               send_frame(pick_content(), len, 1'b0, -1);
            end else if (r < 80) begin
               send_frame(pick_content(), len, 1'b1, -1);
            end else if (r < 87) begin
               if ($urandom_range(0, 1) == 0) len = 16'($urandom_range(MAX_PAYLOAD + 1, 255));
               else len = 16'($urandom_range(256, 65535));
               send_frame(pick_content(), len, 1'b0, -1);
            end else if (r < 94) begin
               send_frame(pick_content(), len, 1'b0, $urandom_range(0, 4));
            end else begin
               send_line(8'($urandom));
            end
         end
      end
   endtask

   initial begin
      sfr_pkg::sfr_cfg_type c;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      directed_items();
      drain();

      write_regs('{8'h00, 8'hFF, 8'hFF, 8'hFF});
      random_items(ITEMS_PER_PHASE, 10);
      drain();

      write_regs('{8'hFF, 8'h00, 8'h01, 8'h00});
      random_items(ITEMS_PER_PHASE, 30);
      drain();

      // a stretch with no idling on either side
      quiet = 1'b1;
      c.frame_mark = 8'($urandom);
      c.esc_code = 8'($urandom);
      while (c.esc_code == c.frame_mark) c.esc_code = 8'($urandom);
      c.esc_xor = 8'($urandom);
      c.crc_poly = 8'($urandom);
      write_regs(c);
      random_items(ITEMS_PER_PHASE, 30);
      drain();
      quiet = 1'b0;

      write_regs('{8'h7E, 8'h7D, 8'h20, 8'h07});
      random_items(ITEMS_PER_PHASE, 35);
      drain();
      repeat (16) @(posedge clock);

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
